/* hdl/twcr_pkg.sv */
`timescale 1ns / 1ps
package twcr_pkg;

	localparam int SCR_HEIGHT = 64;
	localparam int TEX_COLS   = 16;
	localparam int DIV_NW     = 31;
	localparam int DIV_DW     = 16;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_DRAW  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

endpackage

/* hdl/twcr_ram.sv */
`timescale 1ns / 1ps
module twcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* hdl/twcr_div.sv */
`timescale 1ns / 1ps
module twcr_div
	import twcr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], fits};
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;
	assign rsp.rem  = rem_q;

endmodule

/* hdl/textured_wall_column_rasterizer.sv */
`timescale 1ns / 1ps
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | kind, left_*, right_*, texture_number, store_address, word_data
// output  | out_valid| out_stall | read_byte, done_kind
// Load writes the texture word on acceptance, read fetches the frame byte, clear clears both buffers.
// Draw: left clipping does two divides (u, then height), then each column reads its depth byte;
// a drawn column does a divide for the texture column, a read and a write per drawn row and up to
// 16 shift catch-up steps, and each catching-up advance does a divide; the divider is shared.
// After reset a clearing pass runs; in_stall is high.
// One item at a time; a result waiting under out_stall does not block the next transfer in.
module textured_wall_column_rasterizer
	import twcr_pkg::*;
#(
	parameter int SCREEN_WIDTH    = 128,
	parameter int TEXTURE_COUNT   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic signed [15:0] left_x,
	input  logic signed [15:0] left_height,
	input  logic signed [15:0] left_tex_u,
	input  logic signed [15:0] right_x,
	input  logic signed [15:0] right_height,
	input  logic signed [15:0] right_tex_u,
	input  logic [2:0]         texture_number,
	input  logic [9:0]         store_address,
	input  logic [15:0]        word_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         read_byte,
	output logic [1:0]         done_kind
);

	localparam int FRAME_BYTES = SCREEN_WIDTH * SCR_HEIGHT / 8;
	localparam int TEX_WORDS   = TEXTURE_COUNT * TEX_COLS;
	localparam int FA_W        = $clog2(FRAME_BYTES);
	localparam int TA_W        = $clog2(TEX_WORDS);
	localparam int XW          = $clog2(SCREEN_WIDTH);
	localparam int XCW         = $clog2(SCREEN_WIDTH + 1);
	localparam logic signed [15:0] SW16 = 16'(SCREEN_WIDTH);

	typedef enum logic [22:0] {
		ST_CLEAR     = 23'b1 << 0,
		ST_IDLE      = 23'b1 << 1,
		ST_RDF       = 23'b1 << 2,
		ST_START     = 23'b1 << 3,
		ST_CLIP_MUL  = 23'b1 << 4,
		ST_CLIP_GO   = 23'b1 << 5,
		ST_CLIP_WAIT = 23'b1 << 6,
		ST_SETUP     = 23'b1 << 7,
		ST_COL_RD    = 23'b1 << 8,
		ST_COL_CHK   = 23'b1 << 9,
		ST_TEX_GO    = 23'b1 << 10,
		ST_TEX_WAIT  = 23'b1 << 11,
		ST_TEX_RD    = 23'b1 << 12,
		ST_VSET      = 23'b1 << 13,
		ST_SETTLE    = 23'b1 << 14,
		ST_ROW_RD    = 23'b1 << 15,
		ST_ROW_WR    = 23'b1 << 16,
		ST_ADV_W     = 23'b1 << 17,
		ST_ADV_WWAIT = 23'b1 << 18,
		ST_ADV_U     = 23'b1 << 19,
		ST_ADV_UWAIT = 23'b1 << 20,
		ST_NEXT      = 23'b1 << 21,
		ST_DONE      = 23'b1 << 22
	} state_t;

	function automatic logic [2:0] tex_wrap(input logic [2:0] t);
		logic [6:0] v;
		v = {4'b0, t};
		for (int i = 0; i < 8; i++) begin
			if (v >= 7'(TEXTURE_COUNT)) begin
				v = v - 7'(TEXTURE_COUNT);
			end
		end
		return v[2:0];
	endfunction

	state_t state_q;
	logic   clr_item_q;
	logic [FA_W-1:0] clr_q;
	logic   out_valid_q;
	logic [7:0] read_byte_q;
	logic [1:0] done_kind_q;

	logic [1:0]         kind_q;
	logic signed [15:0] x1_q, w1_q, u1_q, x2_q, w2_q, u2_q;
	logic [2:0]         tex_q;
	logic [9:0]         addr_q;
	logic [7:0]         rb_q;
	logic               clip_sel_q;
	logic [15:0]        span_q;
	logic signed [33:0] prod_q;
	logic signed [15:0] w_q, u_q;
	logic signed [17:0] werr_q, uerr_q;
	logic [15:0]        dw_q, du_q;
	logic               wneg_q, uneg_q;
	logic [14:0]        dx_q;
	logic [XCW-1:0]     x_q, xend_q;
	logic               ovw_q;
	logic [TA_W-1:0]    tidx_q;
	logic [15:0]        word_q;
	logic [15:0]        dy_q;
	logic signed [20:0] verr_q;
	logic [4:0]         shift_q;
	logic [6:0]         y_q, yend_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              f_we, d_we, t_we;
	logic [FA_W-1:0]   f_addr;
	logic [XW-1:0]     d_addr;
	logic [TA_W-1:0]   t_addr;
	logic [7:0]        f_wdata, f_rdata, d_wdata, d_rdata;
	logic [15:0]       t_rdata;

	logic              accept;
	logic [11:0]       sa12;
	logic [FA_W-1:0]   row_addr;
	logic [7:0]        sat;
	logic signed [17:0] e_w, e_u;
	logic signed [16:0] negx, clip_diff, dw_diff, du_diff;
	logic [33:0]       prod_abs;
	logic [15:0]       q16, u_abs;
	logic [3:0]        tcol;
	logic [14:0]       half;
	logic              pix;
	logic [7:0]        pmask;
	logic [XCW-1:0]    x_nx;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign read_byte = read_byte_q;
	assign done_kind = done_kind_q;

	assign sa12     = 12'(store_address);
	assign row_addr = FA_W'(FA_W'(y_q[5:3]) * FA_W'(SCREEN_WIDTH)) + FA_W'(x_q[XW-1:0]);
	assign sat      = w_q[15] ? 8'd0 : ((w_q > 16'sd255) ? 8'd255 : w_q[7:0]);
	assign e_w      = werr_q - $signed({2'b0, dw_q});
	assign e_u      = uerr_q - $signed({2'b0, du_q});
	assign negx     = 17'sd0 - 17'(x1_q);
	assign clip_diff = clip_sel_q ? (17'(w2_q) - 17'(w1_q)) : (17'(u2_q) - 17'(u1_q));
	assign dw_diff  = 17'(w2_q) - 17'(w1_q);
	assign du_diff  = 17'(u2_q) - 17'(u1_q);
	assign prod_abs = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
	assign q16      = div_rsp.quo[15:0];
	assign u_abs    = u_q[15] ? 16'(-u_q) : 16'(u_q);
	assign tcol     = u_q[15] ? (~q16[3:0] + 4'd1) : q16[3:0];
	assign half     = w_q[15:1];
	assign pix      = shift_q[4] ? 1'b0 : word_q[shift_q[3:0]];
	assign pmask    = 8'(1) << y_q[2:0];
	assign x_nx     = x_q + XCW'(1);

	always_comb begin
		f_we    = 1'b0;
		f_addr  = row_addr;
		f_wdata = f_rdata;
		d_we    = 1'b0;
		d_addr  = x_q[XW-1:0];
		d_wdata = sat;
		t_we    = 1'b0;
		t_addr  = tidx_q;
		div_req = '0;
		case (state_q)
			ST_CLEAR: begin
				f_we    = 1'b1;
				f_addr  = clr_q;
				f_wdata = 8'd0;
				d_we    = clr_q < FA_W'(SCREEN_WIDTH);
				d_addr  = clr_q[XW-1:0];
				d_wdata = 8'd0;
			end
			ST_IDLE: begin
				f_addr = sa12[FA_W-1:0];
				t_addr = sa12[TA_W-1:0];
				t_we   = accept && (kind == KIND_LOAD) &&
					(11'(store_address) < 11'(TEX_WORDS));
			end
			ST_CLIP_GO: begin
				div_req.start = 1'b1;
				div_req.num   = prod_abs[DIV_NW-1:0];
				div_req.den   = span_q;
			end
			ST_COL_CHK: begin
				d_we = (d_rdata == 8'd0) || (w_q > $signed({8'b0, d_rdata}));
			end
			ST_TEX_GO: begin
				div_req.start = w_q != 16'sd0;
				div_req.num   = DIV_NW'(u_abs);
				div_req.den   = w_q;
			end
			ST_ROW_WR: begin
				f_we    = 1'b1;
				f_wdata = pix ? (f_rdata | pmask) : (ovw_q ? (f_rdata & ~pmask) : f_rdata);
			end
			ST_ADV_W: begin
				div_req.start = e_w[17];
				div_req.num   = DIV_NW'(~e_w);
				div_req.den   = {1'b0, dx_q};
			end
			ST_ADV_U: begin
				div_req.start = e_u[17];
				div_req.num   = DIV_NW'(~e_u);
				div_req.den   = {1'b0, dx_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_item_q  <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + FA_W'(1);
					if (clr_q == FA_W'(FRAME_BYTES - 1)) begin
						clr_q   <= '0;
						state_q <= clr_item_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_LOAD:  state_q <= ST_DONE;
							KIND_DRAW:  state_q <= ST_START;
							KIND_READ:  state_q <= ST_RDF;
							default: begin
								clr_item_q <= 1'b1;
								state_q    <= ST_CLEAR;
							end
						endcase
					end
				end
				ST_RDF: state_q <= ST_DONE;
				ST_START: begin
					if (x1_q[15]) begin
						state_q <= (x2_q <= 16'sd0) ? ST_DONE : ST_CLIP_MUL;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_CLIP_MUL: state_q <= ST_CLIP_GO;
				ST_CLIP_GO:  state_q <= ST_CLIP_WAIT;
				ST_CLIP_WAIT: begin
					if (div_rsp.done) begin
						state_q <= clip_sel_q ? ST_SETUP : ST_CLIP_MUL;
					end
				end
				ST_SETUP: begin
					state_q <= ((x2_q <= x1_q) || (x1_q >= SW16)) ? ST_DONE : ST_COL_RD;
				end
				ST_COL_RD: state_q <= ST_COL_CHK;
				ST_COL_CHK: begin
					if ((d_rdata == 8'd0 && !w_q[15]) || (w_q > $signed({8'b0, d_rdata}))) begin
						state_q <= ST_TEX_GO;
					end else begin
						state_q <= ST_ADV_W;
					end
				end
				ST_TEX_GO:   state_q <= (w_q == 16'sd0) ? ST_TEX_RD : ST_TEX_WAIT;
				ST_TEX_WAIT: if (div_rsp.done) state_q <= ST_TEX_RD;
				ST_TEX_RD:   state_q <= ST_VSET;
				ST_VSET:     state_q <= ST_SETTLE;
				ST_SETTLE: begin
					if (!(verr_q[20] && !shift_q[4])) begin
						state_q <= (y_q < yend_q) ? ST_ROW_RD : ST_ADV_W;
					end
				end
				ST_ROW_RD:    state_q <= ST_ROW_WR;
				ST_ROW_WR:    state_q <= ST_SETTLE;
				ST_ADV_W:     state_q <= e_w[17] ? ST_ADV_WWAIT : ST_ADV_U;
				ST_ADV_WWAIT: if (div_rsp.done) state_q <= ST_ADV_U;
				ST_ADV_U:     state_q <= e_u[17] ? ST_ADV_UWAIT : ST_NEXT;
				ST_ADV_UWAIT: if (div_rsp.done) state_q <= ST_NEXT;
				ST_NEXT:      state_q <= (x_nx < xend_q) ? ST_COL_RD : ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						clr_item_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q <= kind;
					x1_q   <= left_x;
					w1_q   <= left_height;
					u1_q   <= left_tex_u;
					x2_q   <= right_x;
					w2_q   <= right_height;
					u2_q   <= right_tex_u;
					tex_q  <= texture_number;
					addr_q <= store_address;
				end
			end
			ST_RDF: rb_q <= (12'(addr_q) < 12'(FRAME_BYTES)) ? f_rdata : 8'd0;
			ST_START: begin
				span_q     <= 16'(17'(x2_q) - 17'(x1_q));
				clip_sel_q <= 1'b0;
			end
			ST_CLIP_MUL: prod_q <= 34'(negx) * 34'(clip_diff);
			ST_CLIP_WAIT: begin
				if (div_rsp.done) begin
					if (clip_sel_q) begin
						w1_q <= w1_q + (prod_q[33] ? 16'(-q16) : q16);
						x1_q <= 16'sd0;
					end else begin
						u1_q       <= u1_q + (prod_q[33] ? 16'(-q16) : q16);
						clip_sel_q <= 1'b1;
					end
				end
			end
			ST_SETUP: begin
				dx_q   <= 15'(x2_q - x1_q);
				werr_q <= 18'(15'(x2_q - x1_q) >> 1);
				uerr_q <= 18'(15'(x2_q - x1_q) >> 1);
				w_q    <= w1_q;
				u_q    <= u1_q;
				wneg_q <= !(w1_q < w2_q);
				uneg_q <= !(u1_q < u2_q);
				dw_q   <= (w1_q < w2_q) ? dw_diff[15:0] : 16'(-dw_diff);
				du_q   <= (u1_q < u2_q) ? du_diff[15:0] : 16'(-du_diff);
				x_q    <= x1_q[XCW-1:0];
				xend_q <= (x2_q < SW16) ? x2_q[XCW-1:0] : XCW'(SCREEN_WIDTH);
			end
			ST_COL_CHK: ovw_q <= d_rdata != 8'd0;
			ST_TEX_GO: tidx_q <= TA_W'({3'b0, tex_wrap(tex_q), 4'd0});
			ST_TEX_WAIT: begin
				if (div_rsp.done) begin
					tidx_q <= TA_W'({3'b0, tex_wrap(tex_q), tcol});
				end
			end
			ST_VSET: begin
				word_q  <= t_rdata;
				dy_q    <= {half, 1'b1};
				shift_q <= '0;
				if (half > 15'd32) begin
					verr_q <= 21'(half) - 21'({half - 15'd32, 4'b0});
					y_q    <= '0;
				end else begin
					verr_q <= 21'(half);
					y_q    <= 7'(15'd32 - half);
				end
				yend_q <= (half >= 15'd31) ? 7'(SCR_HEIGHT) : 7'(15'd33 + half);
			end
			ST_SETTLE: begin
				if (verr_q[20] && !shift_q[4]) begin
					verr_q  <= verr_q + $signed({5'b0, dy_q});
					shift_q <= shift_q + 5'd1;
				end
			end
			ST_ROW_WR: begin
				verr_q <= verr_q - 21'sd16;
				y_q    <= y_q + 7'd1;
			end
			ST_ADV_W: werr_q <= e_w;
			ST_ADV_WWAIT: begin
				if (div_rsp.done) begin
					w_q    <= wneg_q ? (w_q - (q16 + 16'd1)) : (w_q + (q16 + 16'd1));
					werr_q <= 18'({1'b0, dx_q} - 16'd1 - div_rsp.rem);
				end
			end
			ST_ADV_U: uerr_q <= e_u;
			ST_ADV_UWAIT: begin
				if (div_rsp.done) begin
					u_q    <= uneg_q ? (u_q - (q16 + 16'd1)) : (u_q + (q16 + 16'd1));
					uerr_q <= 18'({1'b0, dx_q} - 16'd1 - div_rsp.rem);
				end
			end
			ST_NEXT: x_q <= x_nx;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					read_byte_q <= (kind_q == KIND_READ) ? rb_q : 8'd0;
					done_kind_q <= kind_q;
				end
			end
			default: begin
			end
		endcase
	end

	twcr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	twcr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
		.clk  (clk),
		.we   (f_we),
		.addr (f_addr),
		.wdata(f_wdata),
		.rdata(f_rdata)
	);

	twcr_ram #(.WIDTH(8), .DEPTH(SCREEN_WIDTH)) u_depth (
		.clk  (clk),
		.we   (d_we),
		.addr (d_addr),
		.wdata(d_wdata),
		.rdata(d_rdata)
	);

	twcr_ram #(.WIDTH(16), .DEPTH(TEX_WORDS)) u_tex (
		.clk  (clk),
		.we   (t_we),
		.addr (t_addr),
		.wdata(word_data),
		.rdata(t_rdata)
	);

endmodule
